// File: design/kwsqm_pkg.sv
`default_nettype none

package kwsqm_pkg;

  // Action codes on the input channel
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_t;

  // Token that walks the cell chain. On a pop, value carries the best head so far.
  typedef struct packed {
    logic               valid;
    logic               action;
    logic [2:0]         queue_index;
    logic signed [31:0] value;
    logic               found;
    status_t            status;
  } token_t;

endpackage

`default_nettype wire

// File: design/k_way_sorted_queue_merge_top.sv
`default_nettype none

// K-way sorted queue merge.
// Each of QUEUES cells keeps one nondecreasing queue of up to QUEUE_DEPTH
// signed 32-bit values in its own memory. A transaction is accepted at a
// rising edge with start high and busy low: action 0 appends value to
// queue queue_index, action 1 pops the smallest head over all queues
// (ties to the lowest index). The transaction travels the cell row as a
// token, one cell per cycle; the matching cell appends, and on a pop each
// cell keeps the smaller head. A pop is then committed to the winning cell.
// Busy is high from accept until done rises; after a pop's done the block
// stays busy in a settle state while the winner's head memory read catches
// up, so it takes no new transaction until the last one is through.
// The result is on popped_value, source_queue and status for exactly one
// cycle with done high; the receiver cannot stall it.
// Reset empties every queue and returns the block to idle.
module k_way_sorted_queue_merge_top #(
  parameter int QUEUES      = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action,
  input  wire logic [2:0]         queue_index,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [31:0]      popped_value,
  output logic [2:0]              source_queue,
  output kwsqm_pkg::status_t      status
);
  import kwsqm_pkg::*;

  localparam int QW = $clog2(QUEUES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SETTLE
  } state_t;

  state_t        state;
  token_t        tok [QUEUES+1];
  logic [QW-1:0] idx [QUEUES+1];
  token_t        tok_inject;
  logic          commit_en;
  logic [QW-1:0] commit_idx;
  token_t        tok_end;
  logic [QW-1:0] idx_end;

  assign busy    = state != S_IDLE;
  assign tok[0]  = tok_inject;
  assign idx[0]  = '0;
  assign tok_end = tok[QUEUES];
  assign idx_end = idx[QUEUES];

  // Row of queue cells
  for (genvar i = 0; i < QUEUES; i++) begin : g_cell
    kwsqm_cell #(
      .IDX         (i),
      .QUEUES      (QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[i]),
      .idx_in     (idx[i]),
      .tok_out    (tok[i+1]),
      .idx_out    (idx[i+1]),
      .commit_en  (commit_en),
      .commit_idx (commit_idx)
    );
  end

  // Sequencer: inject token, collect result, commit pop
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      tok_inject.valid <= 1'b0;
      done             <= 1'b0;
      commit_en        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          tok_inject.valid <= start;
          done             <= 1'b0;
          commit_en        <= 1'b0;
          if (start) begin
            tok_inject.action      <= action;
            tok_inject.queue_index <= queue_index;
            tok_inject.value       <= value;
            tok_inject.found       <= 1'b0;
            tok_inject.status      <= ST_FULL;
            state                  <= S_RUN;
          end
        end
        S_RUN: begin
          tok_inject.valid <= 1'b0;
          done             <= tok_end.valid;
          if (tok_end.valid) begin
            if (tok_end.action == ACT_APPEND) begin
              popped_value <= '0;
              source_queue <= '0;
              status       <= tok_end.status;
              commit_en    <= 1'b0;
              state        <= S_IDLE;
            end else if (tok_end.found) begin
              popped_value <= tok_end.value;
              source_queue <= 3'(idx_end);
              status       <= ST_OK;
              commit_en    <= 1'b1;
              commit_idx   <= idx_end;
              state        <= S_SETTLE;
            end else begin
              popped_value <= '0;
              source_queue <= '0;
              status       <= ST_EMPTY;
              commit_en    <= 1'b0;
              state        <= S_IDLE;
            end
          end else begin
            commit_en <= 1'b0;
          end
        end
        S_SETTLE: begin
          tok_inject.valid <= 1'b0;
          done             <= 1'b0;
          commit_en        <= 1'b0;
          state            <= S_IDLE;
        end
        default: begin
          tok_inject.valid <= 1'b0;
          done             <= 1'b0;
          commit_en        <= 1'b0;
          state            <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/kwsqm_cell.sv
`default_nettype none

module kwsqm_cell #(
  parameter int IDX         = 0,
  parameter int QUEUES      = 8,
  parameter int QUEUE_DEPTH = 64,
  localparam int QW = $clog2(QUEUES),
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kwsqm_pkg::token_t tok_in,
  input  wire logic [QW-1:0]     idx_in,
  output kwsqm_pkg::token_t      tok_out,
  output logic [QW-1:0]          idx_out,
  input  wire logic              commit_en,
  input  wire logic [QW-1:0]     commit_idx
);
  import kwsqm_pkg::*;

  logic signed [31:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]      head;
  logic [CW-1:0]      count;
  logic signed [31:0] last;
  logic signed [31:0] head_rd;

  logic               my_sel;
  logic               is_full;
  logic               is_empty;
  logic               out_of_order;
  logic               do_append;
  logic               take;
  logic               do_commit;
  logic [CW:0]        tail_sum;
  logic [PW-1:0]      tail;
  token_t             tok_next;
  logic [QW-1:0]      idx_next;

  // Local queue checks
  assign my_sel       = 32'(tok_in.queue_index) == IDX;
  assign is_full      = count == CW'(QUEUE_DEPTH);
  assign is_empty     = count == '0;
  assign out_of_order = !is_empty && (tok_in.value < last);
  assign do_append    = tok_in.valid && tok_in.action == ACT_APPEND && my_sel &&
                        !is_full && !out_of_order;
  assign take         = tok_in.valid && tok_in.action == ACT_POP && !is_empty &&
                        (!tok_in.found || head_rd < tok_in.value);
  assign do_commit    = commit_en && commit_idx == QW'(IDX);

  // Ring tail: head + count stays below twice the depth
  assign tail_sum = (CW+1)'(head) + (CW+1)'(count);
  assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                    ? PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);

  // Token update for this cell
  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    if (tok_in.action == ACT_APPEND && my_sel) begin
      if (is_full) begin
        tok_next.status = ST_FULL;
      end else if (out_of_order) begin
        tok_next.status = ST_ORDER;
      end else begin
        tok_next.status = ST_OK;
      end
    end
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.value = head_rd;
      idx_next       = QW'(IDX);
    end
  end

  // Chain stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      idx_out <= '0;
    end else begin
      tok_out <= tok_next;
      idx_out <= idx_next;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (do_append) begin
      count <= count + CW'(1);
    end else if (do_commit) begin
      count <= count - CW'(1);
      head  <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
    end
  end

  // Queue storage; head entry read every cycle
  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[tail] <= tok_in.value;
      last      <= tok_in.value;
    end
    head_rd <= mem[head];
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_commit_nonempty: assert property (@(posedge clk) disable iff (rst)
    do_commit |-> !is_empty)
    else $error("pop committed on empty queue");

  a_token_moves: assert property (@(posedge clk) disable iff (rst)
    tok_in.valid |=> tok_out.valid)
    else $error("token lost in cell");

endmodule

`default_nettype wire

// File: test/tb_k_way_sorted_queue_merge_top.sv
`timescale 1ns / 100ps

module tb_k_way_sorted_queue_merge_top;
  import kwsqm_pkg::*;

  localparam int QUEUES       = 8;
  localparam int QUEUE_DEPTH  = 64;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4 * (QUEUES + 3);
  localparam int ITEMS_PHASE  = 320;
  localparam int PRINT_CAP    = 50;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                action;
  logic [2:0]          queue_index;
  logic signed [31:0]  value;
  logic                done;
  logic signed [31:0]  popped_value;
  logic [2:0]          source_queue;
  status_t             status;

  // percent of cycles in which the sender holds start low
  int unsigned idle_pct;
  int unsigned stall_cycles;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [2:0]         src;
    status_t            st;
  } merge_result_t;

  // Shadow of the queues plus the list of results still to come
  class merge_scoreboard;
    logic signed [31:0] store [QUEUES][QUEUE_DEPTH];
    int unsigned        head [QUEUES];
    int unsigned        fill [QUEUES];
    logic signed [31:0] tail_value [QUEUES];
    merge_result_t      awaited [$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < QUEUES; i++) begin
        head[i] = 0;
        fill[i] = 0;
        tail_value[i] = '0;
      end
      mismatches = 0;
    endfunction

    // Apply one accepted transaction and queue the result it must produce
    function void note_item(logic act, logic [2:0] qi, logic signed [31:0] v);
      merge_result_t r;
      int            best;
      int unsigned   slot;
      r.popped = '0;
      r.src    = '0;
      r.st     = ST_OK;
      if (act == ACT_APPEND) begin
        if (int'(qi) >= QUEUES || fill[qi] >= QUEUE_DEPTH) begin
          r.st = ST_FULL;
        end else if (fill[qi] > 0 && v < tail_value[qi]) begin
          r.st = ST_ORDER;
        end else begin
          slot = (head[qi] + fill[qi]) % QUEUE_DEPTH;
          store[qi][slot] = v;
          fill[qi]++;
          tail_value[qi] = v;
        end
      end else begin
        // smallest head wins, strict compare keeps ties on the lowest index
        best = -1;
        for (int i = 0; i < QUEUES; i++) begin
          if (fill[i] != 0 && (best < 0 || store[i][head[i]] < store[best][head[best]]))
            best = i;
        end
        if (best < 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.popped   = store[best][head[best]];
          r.src      = best[2:0];
          head[best] = (head[best] + 1) % QUEUE_DEPTH;
          fill[best]--;
        end
      end
      awaited = {awaited, r};
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic signed [31:0] pv, logic [2:0] sq, status_t st);
      merge_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result value=%0d src=%0d status=%s",
                         pv, sq, st.name()));
        return;
      end
      e = awaited.pop_front();
      if (pv !== e.popped)
        report($sformatf("popped_value %0d, want %0d", pv, e.popped));
      if (sq !== e.src)
        report($sformatf("source_queue %0d, want %0d", sq, e.src));
      if (st !== e.st)
        report($sformatf("status %s, want %s", st.name(), e.st.name()));
    endtask
  endclass

  merge_scoreboard sb;

  k_way_sorted_queue_merge_top #(
    .QUEUES      (QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .queue_index  (queue_index),
    .value        (value),
    .done         (done),
    .popped_value (popped_value),
    .source_queue (source_queue),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(popped_value, source_queue, status);
  end

  // Watchdog: cycles with neither an accepted transaction nor a result
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Present one transaction at the falling edge, hold it until accepted
  task automatic send_item(logic act, logic [2:0] qi, logic signed [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start       = 1'b1;
    action      = act;
    queue_index = qi;
    value       = v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(act, qi, v);
  endtask

  // Pop with junk on the ignored fields
  task automatic pop_head();
    send_item(ACT_POP, 3'($urandom_range(7)), $urandom());
  endtask

  // Mostly nondecreasing values for a queue, with ties and some out-of-order ones
  function automatic logic signed [31:0] next_value(int unsigned qi);
    int unsigned        pick;
    longint             cand;
    logic signed [31:0] last;
    pick = $urandom_range(99);
    last = sb.tail_value[qi];
    if (sb.fill[qi] == 0 || pick < 8) return $urandom();
    if (pick < 18) return last;
    if (pick < 26) begin
      cand = longint'(last) - longint'($urandom_range(1, 1000));
      if (cand < longint'(VAL_MIN)) cand = longint'(VAL_MIN);
      return cand[31:0];
    end
    cand = longint'(last) + longint'($urandom_range(1, 1 << 20));
    if (cand > longint'(VAL_MAX)) cand = longint'(VAL_MAX);
    return cand[31:0];
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned qi;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      qi   = $urandom_range(QUEUES - 1);
      if (pick < 3) begin
        // run one queue past full, last one below its tail
        for (int k = 0; k < QUEUE_DEPTH + 2; k++)
          send_item(ACT_APPEND, qi[2:0], next_value(qi));
        send_item(ACT_APPEND, qi[2:0], VAL_MIN);
        sent += QUEUE_DEPTH + 3;
      end else if (pick < 6) begin
        // pop QUEUE_DEPTH + 8 times, past empty if the queues hold fewer
        repeat (QUEUE_DEPTH + 8) pop_head();
        sent += QUEUE_DEPTH + 8;
      end else if (pick < 50) begin
        pop_head();
        sent++;
      end else begin
        send_item(ACT_APPEND, qi[2:0], next_value(qi));
        sent++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    action       = ACT_APPEND;
    queue_index  = '0;
    value        = '0;
    idle_pct     = 0;
    sb           = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, ties, order rejects, empty pops, reuse of a drained queue
    pop_head();
    send_item(ACT_APPEND, 3'd0, VAL_MIN);
    send_item(ACT_APPEND, 3'd0, VAL_MIN);
    send_item(ACT_APPEND, 3'd7, VAL_MAX);
    send_item(ACT_APPEND, 3'd7, VAL_MAX - 1);
    send_item(ACT_APPEND, 3'd7, VAL_MAX);
    send_item(ACT_APPEND, 3'd3, 32'sd0);
    send_item(ACT_APPEND, 3'd2, 32'sd5);
    send_item(ACT_APPEND, 3'd5, 32'sd5);
    send_item(ACT_APPEND, 3'd3, -32'sd1);
    repeat (8) pop_head();
    send_item(ACT_APPEND, 3'd6, 32'sd100);
    pop_head();
    send_item(ACT_APPEND, 3'd6, -32'sd50);
    send_item(ACT_APPEND, 3'd1, -32'sd50);
    pop_head();
    pop_head();
    pop_head();

    // Random phases with the sender idle 0, 85, 0 and 29 percent; the receiver cannot stall
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 85;
        2: idle_pct = 0;
        default: idle_pct = 29;
      endcase
      random_items(ITEMS_PHASE);
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/kwsqm_pkg.sv
design/kwsqm_cell.sv
design/k_way_sorted_queue_merge_top.sv
test/tb_k_way_sorted_queue_merge_top.sv
